FILE: rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_AW    = 1;
    localparam int REQ_W     = 2;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int DIN_W     = 16;
    localparam int DOUT_W    = 32;
    localparam int OUT_PAD_W = DOUT_W - (1 + IDX_W + 1 + CNT_W);
    localparam int IN_PAD_W  = DIN_W - IDX_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1FFF;

    localparam logic [CFG_AW-1:0] REG_TOTAL_BLOCKS = 1'd0;
    localparam logic [CFG_AW-1:0] REG_META_BLOCKS  = 1'd1;

    localparam logic [CFG_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;
    localparam logic [CFG_W-1:0] META_BLOCKS_RST  = 13'd0;

    typedef enum logic [REQ_W-1:0] {
        REQ_FORMAT  = 2'd0,
        REQ_RESERVE = 2'd1,
        REQ_FREE    = 2'd2,
        REQ_QUERY   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FMT,
        ST_SCAN,
        ST_LOCATE,
        ST_MODIFY,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/bitmap_block_allocator.sv
// Format rewrites every map word in turn; reserve scans the map words in order for
// a clear bit; free and query step to the word that holds the block and read it.
// One request at a time; the next transfer in is taken once the result is loaded,
// and a result held by the receiver holds off the input as well.
// Reset: async active low; clears control state, then a clearing pass over all
// MAP_WORDS map words (64 by default) zeroes the map before the first request.
`default_nettype none

module bitmap_block_allocator #(
    parameter int MAX_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // req_type[1:0]
    input  logic [bba_pkg::REQ_W-1:0]        s_axis_tuser,
    // block_index[11:0]
    input  logic [bba_pkg::DIN_W-1:0]        s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // status[0], result_block[12:1], block_busy[13], free_count[26:14]
    output logic [bba_pkg::DOUT_W-1:0]       m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [bba_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [bba_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int WB        = MAP_WORD_BITS;
    localparam int MAP_WORDS = (MAX_BLOCKS + WB - 1) / WB;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WB);
    localparam int MAX_W     = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W     = (MAX_W > bba_pkg::CFG_W) ? MAX_W : bba_pkg::CFG_W;
    localparam int BASE_W    = CMP_W + 1;
    localparam int IDX_W     = bba_pkg::IDX_W;
    localparam int CNT_W     = bba_pkg::CNT_W;

    localparam logic [BASE_W-1:0] WB_STEP   = BASE_W'(WB);
    localparam logic [BASE_W-1:0] MAX_EXT   = BASE_W'(MAX_BLOCKS);
    localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);

    bba_pkg::state_t state_reg, state_next;
    bba_pkg::req_t   req_reg, req_next;
    bba_pkg::req_t   in_req;

    logic [bba_pkg::CFG_W-1:0] total_blocks_reg, meta_blocks_reg;
    logic [AW-1:0]             word_reg, word_next;
    logic [BASE_W-1:0]         base_reg, base_next;
    logic                      chk_vld_reg, chk_vld_next;
    logic [AW-1:0]             chk_word_reg, chk_word_next;
    logic [BASE_W-1:0]         chk_base_reg, chk_base_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          free_blocks_reg, free_blocks_next;
    logic                      res_status_reg, res_status_next;
    logic [IDX_W-1:0]          res_block_reg, res_block_next;
    logic                      res_busy_reg, res_busy_next;
    logic                      out_valid_reg, out_valid_next;
    logic [bba_pkg::DOUT_W-1:0] out_data_reg, out_data_next;

    logic [BASE_W-1:0] tot, meta_eff, free_ext, idx_ext, in_idx_ext, cand, fill_limit;
    logic [IDX_W-1:0]  in_idx;
    logic              s_fire, issue, scan_hit;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [WB-1:0]     mem_wdata, mem_rdata;

    logic              zero_found, bit_val;
    logic [BIT_W-1:0]  zero_pos, bit_sel;
    logic [WB-1:0]     set_word, clr_word, fill_word;

    assign tot      = (BASE_W'(total_blocks_reg) > MAX_EXT) ? MAX_EXT
                                                           : BASE_W'(total_blocks_reg);
    assign meta_eff = (BASE_W'(meta_blocks_reg) > tot) ? tot : BASE_W'(meta_blocks_reg);
    assign free_ext = BASE_W'(free_blocks_reg);
    assign idx_ext  = BASE_W'(idx_reg);

    assign in_req     = bba_pkg::req_t'(s_axis_tuser);
    assign in_idx     = s_axis_tdata[IDX_W-1:0];
    assign in_idx_ext = BASE_W'(in_idx);

    assign s_axis_tready = (state_reg == bba_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign bit_sel    = BIT_W'(idx_ext - base_reg);
    assign fill_limit = (state_reg == bba_pkg::ST_CLEAR) ? '0 : meta_eff;
    assign issue      = base_reg < tot;
    assign cand       = chk_base_reg + BASE_W'(zero_pos);
    assign scan_hit   = chk_vld_reg && zero_found && (cand < tot);

    bba_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WB),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bba_word_unit #(
        .WB     (WB),
        .BIT_W  (BIT_W),
        .BASE_W (BASE_W)
    ) u_word_unit (
        .word_in    (mem_rdata),
        .bit_sel    (bit_sel),
        .fill_base  (base_reg),
        .fill_limit (fill_limit),
        .zero_found (zero_found),
        .zero_pos   (zero_pos),
        .set_word   (set_word),
        .clr_word   (clr_word),
        .bit_val    (bit_val),
        .fill_word  (fill_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= bba_pkg::TOTAL_BLOCKS_RST;
            meta_blocks_reg  <= bba_pkg::META_BLOCKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                bba_pkg::REG_TOTAL_BLOCKS: total_blocks_reg <= cfg_wdata;
                bba_pkg::REG_META_BLOCKS:  meta_blocks_reg  <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bba_pkg::ST_CLEAR;
            word_reg        <= '0;
            base_reg        <= '0;
            chk_vld_reg     <= 1'b0;
            free_blocks_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            word_reg        <= word_next;
            base_reg        <= base_next;
            chk_vld_reg     <= chk_vld_next;
            free_blocks_reg <= free_blocks_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        chk_word_reg   <= chk_word_next;
        chk_base_reg   <= chk_base_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_busy_reg   <= res_busy_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        word_next        = word_reg;
        base_next        = base_reg;
        chk_vld_next     = chk_vld_reg;
        chk_word_next    = chk_word_reg;
        chk_base_next    = chk_base_reg;
        free_blocks_next = free_blocks_reg;
        res_status_next  = res_status_reg;
        res_block_next   = res_block_reg;
        res_busy_next    = res_busy_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = word_reg;
        mem_wdata        = fill_word;
        mem_re           = 1'b0;
        mem_raddr        = word_reg;

        unique case (state_reg)
            bba_pkg::ST_CLEAR, bba_pkg::ST_FMT:
            begin
                mem_we = 1'b1;
                if (word_reg == LAST_WORD)
                begin
                    word_next = '0;
                    base_next = '0;
                    if (state_reg == bba_pkg::ST_CLEAR)
                    begin
                        state_next = bba_pkg::ST_IDLE;
                    end
                    else
                    begin
                        free_blocks_next = CNT_W'(tot - meta_eff);
                        state_next       = bba_pkg::ST_RESP;
                    end
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                    base_next = base_reg + WB_STEP;
                end
            end

            bba_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    req_next        = in_req;
                    idx_next        = in_idx;
                    word_next       = '0;
                    base_next       = '0;
                    chk_vld_next    = 1'b0;
                    res_status_next = 1'b0;
                    res_block_next  = '0;
                    res_busy_next   = 1'b0;
                    unique case (in_req)
                        bba_pkg::REQ_FORMAT:
                        begin
                            state_next = bba_pkg::ST_FMT;
                        end
                        bba_pkg::REQ_RESERVE:
                        begin
                            if (free_blocks_reg == '0)
                            begin
                                res_status_next = 1'b1;
                                state_next      = bba_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = bba_pkg::ST_SCAN;
                            end
                        end
                        bba_pkg::REQ_FREE:
                        begin
                            res_block_next = in_idx;
                            if (in_idx_ext >= tot)
                            begin
                                res_status_next = 1'b1;
                                state_next      = bba_pkg::ST_RESP;
                            end
                            else if (free_ext == tot)
                            begin
                                state_next = bba_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = bba_pkg::ST_LOCATE;
                            end
                        end
                        bba_pkg::REQ_QUERY:
                        begin
                            res_block_next = in_idx;
                            if (in_idx_ext >= tot)
                            begin
                                res_status_next = 1'b1;
                                state_next      = bba_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = bba_pkg::ST_LOCATE;
                            end
                        end
                    endcase
                end
            end

            bba_pkg::ST_SCAN:
            begin
                mem_re        = issue;
                chk_vld_next  = issue;
                chk_word_next = word_reg;
                chk_base_next = base_reg;
                if (issue)
                begin
                    word_next = word_reg + 1'b1;
                    base_next = base_reg + WB_STEP;
                end
                if (scan_hit)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = chk_word_reg;
                    mem_wdata        = set_word;
                    free_blocks_next = free_blocks_reg - 1'b1;
                    res_block_next   = IDX_W'(cand);
                    state_next       = bba_pkg::ST_RESP;
                end
                else if ((chk_vld_reg && zero_found) || (!chk_vld_reg && !issue))
                begin
                    res_status_next = 1'b1;
                    state_next      = bba_pkg::ST_RESP;
                end
            end

            bba_pkg::ST_LOCATE:
            begin
                if (idx_ext < base_reg + WB_STEP)
                begin
                    mem_re     = 1'b1;
                    state_next = bba_pkg::ST_MODIFY;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                    base_next = base_reg + WB_STEP;
                end
            end

            bba_pkg::ST_MODIFY:
            begin
                if (req_reg == bba_pkg::REQ_QUERY)
                begin
                    res_busy_next = bit_val;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = clr_word;
                    if (free_blocks_reg != bba_pkg::COUNT_MAX)
                    begin
                        free_blocks_next = free_blocks_reg + 1'b1;
                    end
                end
                state_next = bba_pkg::ST_RESP;
            end

            bba_pkg::ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{bba_pkg::OUT_PAD_W{1'b0}}, free_blocks_reg,
                                      res_busy_reg, res_block_reg, res_status_reg};
                    state_next     = bba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_fmt_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_req == bba_pkg::REQ_FORMAT) |=> state_reg == bba_pkg::ST_FMT)
        else $error("format did not start the map walk");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_IDLE) |-> !mem_we)
        else $error("map written while idle");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_SCAN && scan_hit)
            |=> free_blocks_reg == $past(free_blocks_reg) - 1'b1)
        else $error("reserve did not decrement the free count");

    a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == bba_pkg::ST_RESP)
        else $error("result loaded outside the response step");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_SCAN && mem_re) |-> base_reg < tot)
        else $error("scan read past the active block range");

endmodule

`default_nettype wire

FILE: rtl/bba_map_ram.sv
`default_nettype none

module bba_map_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/bba_word_unit.sv
`default_nettype none

module bba_word_unit #(
    parameter int WB     = 64,
    parameter int BIT_W  = 6,
    parameter int BASE_W = 14
) (
    input  logic [WB-1:0]     word_in,
    input  logic [BIT_W-1:0]  bit_sel,
    input  logic [BASE_W-1:0] fill_base,
    input  logic [BASE_W-1:0] fill_limit,
    output logic              zero_found,
    output logic [BIT_W-1:0]  zero_pos,
    output logic [WB-1:0]     set_word,
    output logic [WB-1:0]     clr_word,
    output logic              bit_val,
    output logic [WB-1:0]     fill_word
);

    logic [BASE_W-1:0] diff;
    logic              above;

    // lowest clear bit
    always_comb
    begin
        zero_found = 1'b0;
        zero_pos   = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (!word_in[i])
            begin
                zero_found = 1'b1;
                zero_pos   = BIT_W'(i);
            end
        end
    end

    assign set_word = word_in | (WB'(1) << zero_pos);
    assign clr_word = word_in & ~(WB'(1) << bit_sel);
    assign bit_val  = word_in[bit_sel];

    // ones for every bit below the fill limit
    assign above = fill_limit > fill_base;
    assign diff  = fill_limit - fill_base;

    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            fill_word[i] = above && (BASE_W'(i) < diff);
        end
    end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;

    localparam int MAX_BLOCKS  = 4096;
    localparam int N_PHASES    = 17;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYC   = 80;

    typedef struct packed {
        bba_pkg::req_t             kind;
        logic [bba_pkg::IDX_W-1:0] idx;
    } alloc_req_t;

    typedef struct packed {
        logic                      status;
        logic [bba_pkg::IDX_W-1:0] block;
        logic                      busy;
        logic [bba_pkg::CNT_W-1:0] count;
    } alloc_rsp_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic [bba_pkg::REQ_W-1:0]  s_axis_tuser = '0;
    logic [bba_pkg::DIN_W-1:0]  s_axis_tdata = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [bba_pkg::DOUT_W-1:0] m_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [bba_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [bba_pkg::CFG_W-1:0]  cfg_wdata = '0;

    bitmap_block_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // allocator shadow
    bit                        busy_bits [MAX_BLOCKS];
    logic [bba_pkg::CNT_W-1:0] free_left = '0;
    logic [bba_pkg::CFG_W-1:0] cfg_total = bba_pkg::TOTAL_BLOCKS_RST;
    logic [bba_pkg::CFG_W-1:0] cfg_meta  = bba_pkg::META_BLOCKS_RST;

    alloc_req_t pending_reqs[$];
    alloc_rsp_t expected_rsps[$];
    alloc_req_t in_flight;
    alloc_rsp_t want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_arm = 1'b0;
    int hold_left = 0;

    int err_cnt = 0;
    int n_kind [4] = '{0, 0, 0, 0};
    int n_failed = 0;
    int n_settings = 0;

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned active_blocks();
        return (cfg_total > MAX_BLOCKS) ? MAX_BLOCKS : cfg_total;
    endfunction

    function automatic alloc_rsp_t predict_alloc(alloc_req_t rq);
        alloc_rsp_t  r;
        int unsigned tot;
        int unsigned meta;
        bit          found;
        r = '0;
        found = 1'b0;
        tot = active_blocks();
        case (rq.kind)
            bba_pkg::REQ_FORMAT: begin
                meta = (cfg_meta > tot) ? tot : cfg_meta;
                for (int i = 0; i < MAX_BLOCKS; i++)
                    busy_bits[i] = (i < meta);
                free_left = bba_pkg::CNT_W'(tot - meta);
            end
            bba_pkg::REQ_RESERVE: begin
                if (free_left != 0) begin
                    for (int i = 0; i < tot; i++) begin
                        if (!found && !busy_bits[i]) begin
                            busy_bits[i] = 1'b1;
                            found = 1'b1;
                            r.block = bba_pkg::IDX_W'(i);
                        end
                    end
                end
                if (found)
                    free_left = free_left - 1'b1;
                r.status = !found;
            end
            bba_pkg::REQ_FREE: begin
                r.block = rq.idx;
                if (rq.idx >= tot) begin
                    r.status = 1'b1;
                end
                else if (free_left != tot) begin
                    busy_bits[rq.idx] = 1'b0;
                    if (free_left != bba_pkg::COUNT_MAX)
                        free_left = free_left + 1'b1;
                end
            end
            default: begin
                r.block = rq.idx;
                if (rq.idx >= tot)
                    r.status = 1'b1;
                else
                    r.busy = busy_bits[rq.idx];
            end
        endcase
        r.count = free_left;
        return r;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_rsps.push_back(predict_alloc(in_flight));
                n_kind[in_flight.kind]++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending_reqs.pop_front();
                    s_axis_tuser <= in_flight.kind;
                    s_axis_tdata <= {{bba_pkg::IN_PAD_W{1'b0}}, in_flight.idx};
                    s_axis_tvalid <= 1'b1;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(input string name, input logic [12:0] e, input logic [12:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            err_cnt++;
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: result %h with nothing outstanding, expected none",
                             $time, m_axis_tdata);
                    err_cnt++;
                end
                else begin
                    want = expected_rsps.pop_front();
                    check_field("status", 13'(want.status), 13'(m_axis_tdata[0]));
                    check_field("result_block", 13'(want.block), 13'(m_axis_tdata[12:1]));
                    check_field("block_busy", 13'(want.busy), 13'(m_axis_tdata[13]));
                    check_field("free_count", want.count, m_axis_tdata[26:14]);
                    if (want.status)
                        n_failed++;
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_req(input bba_pkg::req_t k, input int unsigned idx);
        alloc_req_t rq;
        rq.kind = k;
        rq.idx = bba_pkg::IDX_W'(idx);
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bba_pkg::CFG_AW-1:0] addr,
                             input int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= bba_pkg::CFG_W'(value);
        if (addr == bba_pkg::REG_TOTAL_BLOCKS)
            cfg_total = bba_pkg::CFG_W'(value);
        else
            cfg_meta = bba_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input int unsigned tot, input int unsigned meta);
        write_reg(bba_pkg::REG_TOTAL_BLOCKS, tot);
        write_reg(bba_pkg::REG_META_BLOCKS, meta);
        n_settings++;
    endtask

    function automatic int unsigned pick_index();
        int unsigned act;
        int unsigned r;
        act = active_blocks();
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(act - 1, 0);
        else if (r < 85)
            return $urandom_range(4095, 0);
        case ($urandom_range(3))
            0: return 0;
            1: return act - 1;
            2: return (act > 4095) ? 4095 : act;
            default: return 4095;
        endcase
    endfunction

    initial begin
        int unsigned tot;
        int unsigned meta;
        int unsigned r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: empty count, then a free before any format
        push_req(bba_pkg::REQ_RESERVE, 0);
        push_req(bba_pkg::REQ_FREE, 4095);
        push_req(bba_pkg::REQ_RESERVE, 0);
        push_req(bba_pkg::REQ_QUERY, 0);
        push_req(bba_pkg::REQ_FORMAT, 0);
        push_req(bba_pkg::REQ_FREE, 5);
        wait_idle();

        // small device: fill it, double free, count out of step with map
        set_geometry(8, 2);
        push_req(bba_pkg::REQ_FORMAT, 0);
        repeat (7) push_req(bba_pkg::REQ_RESERVE, 0);
        push_req(bba_pkg::REQ_FREE, 3);
        push_req(bba_pkg::REQ_FREE, 3);
        push_req(bba_pkg::REQ_RESERVE, 0);
        push_req(bba_pkg::REQ_RESERVE, 0);
        push_req(bba_pkg::REQ_FREE, 8);
        push_req(bba_pkg::REQ_QUERY, 7);
        push_req(bba_pkg::REQ_QUERY, 4095);
        wait_idle();

        // oversized registers
        set_geometry(8191, 8191);
        push_req(bba_pkg::REQ_FORMAT, 0);
        push_req(bba_pkg::REQ_RESERVE, 0);
        push_req(bba_pkg::REQ_QUERY, 4095);
        wait_idle();

        // shrink without format: count above the active range
        set_geometry(4096, 0);
        push_req(bba_pkg::REQ_FORMAT, 0);
        wait_idle();
        write_reg(bba_pkg::REG_TOTAL_BLOCKS, 4);
        push_req(bba_pkg::REQ_FREE, 2);
        push_req(bba_pkg::REQ_RESERVE, 0);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin tot = 4096; meta = 0; end
                1: begin tot = 1; meta = 0; end
                2: begin tot = 1; meta = 1; end
                3: begin tot = 8191; meta = 8191; end
                4: begin tot = 64; meta = 64; end
                5: begin tot = 4095; meta = 4094; end
                default: begin
                    tot = ($urandom_range(9) == 0) ? $urandom_range(8191, 1)
                                                   : $urandom_range(160, 1);
                    r = $urandom_range(9);
                    if (r < 3)
                        meta = 0;
                    else if (r < 9)
                        meta = $urandom_range(tot / 2, 0);
                    else
                        meta = $urandom_range(8191, 0);
                end
            endcase
            set_geometry(tot, meta);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (p == 6) begin
                @(posedge clk);
                hold_arm <= 1'b1;
                @(posedge clk);
                hold_arm <= 1'b0;
                @(negedge clk);
            end
            if (p % 5 != 3)
                push_req(bba_pkg::REQ_FORMAT, 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 4)
                    push_req(bba_pkg::REQ_FORMAT, $urandom_range(4095, 0));
                else if (r < 44)
                    push_req(bba_pkg::REQ_RESERVE, $urandom_range(4095, 0));
                else if (r < 72)
                    push_req(bba_pkg::REQ_FREE, pick_index());
                else
                    push_req(bba_pkg::REQ_QUERY, pick_index());
            end
            wait_idle();
        end

        repeat (DRAIN_CYC) @(negedge clk);
        $display("Covered %0d formats, %0d reserves, %0d frees, %0d queries",
                 n_kind[bba_pkg::REQ_FORMAT], n_kind[bba_pkg::REQ_RESERVE],
                 n_kind[bba_pkg::REQ_FREE], n_kind[bba_pkg::REQ_QUERY]);
        $display("over %0d device geometries; %0d requests reported failure",
                 n_settings, n_failed);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: bitmap_block_allocator.f
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_word_unit.sv
rtl/bitmap_block_allocator.sv
dv/testbench.sv
